[rtl/ldps_pkg.sv]
// Shared types and constants for the pair linkage statistics block.
package ldps_pkg;

  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_WIDTH    = FRACTION_BITS + 1;
  localparam int LOD_WIDTH     = 25;
  localparam int LOG_FRAC      = 30;

  localparam int MARG_BITS  = COUNT_BITS + 1;
  localparam int TOTAL_BITS = COUNT_BITS + 2;
  localparam int EXP_BITS   = $clog2(TOTAL_BITS);
  localparam int LOG_BITS   = LOG_FRAC + EXP_BITS;
  localparam int SHIFT_BITS = $clog2(LOG_FRAC + 1);

  localparam int PROD_BITS = 2 * COUNT_BITS;
  localparam int MIN_BITS  = 2 * MARG_BITS;
  localparam int SQ_BITS   = 4 * COUNT_BITS;
  localparam int DEN_BITS  = 4 * MARG_BITS;

  localparam int TERM_BITS = COUNT_BITS + LOG_BITS + 1;
  localparam int SUM_BITS  = COUNT_BITS + LOG_BITS + 3;
  localparam int LOD_SPLIT = SUM_BITS / 2;
  localparam int LOD_SHIFT = 54;
  localparam int LOD_RAW_BITS  = SUM_BITS + 32;
  localparam int LOD_PROD_BITS = (LOD_RAW_BITS > LOD_SHIFT + LOD_WIDTH) ?
                                 LOD_RAW_BITS : LOD_SHIFT + LOD_WIDTH + 1;
  localparam logic [31:0] LOG10_2_Q32 = 32'h4D104D42;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count_a1b1;
    logic [COUNT_BITS-1:0] count_a1b2;
    logic [COUNT_BITS-1:0] count_a2b1;
    logic [COUNT_BITS-1:0] count_a2b2;
  } in_item_t;

  typedef struct packed {
    logic [FRAC_WIDTH-1:0] dprime_frac;
    logic [FRAC_WIDTH-1:0] rsquared_frac;
    logic [LOD_WIDTH-1:0]  lod_score;
    logic                  empty_input;
  } out_item_t;

  typedef struct packed {
    in_item_t              cnt;
    logic [MARG_BITS-1:0]  n_a1;
    logic [MARG_BITS-1:0]  n_a2;
    logic [MARG_BITS-1:0]  n_b1;
    logic [MARG_BITS-1:0]  n_b2;
    logic [TOTAL_BITS-1:0] n_all;
    logic                  empty;
  } work_t;

endpackage

[rtl/ld_pair_statistics_core.sv]
// Linkage statistics for pairs of loci: top level joining front end, queue and back end.
// Takes one item of four haplotype counts per clock and returns one item per clock
// while out_stall is low, with D', r squared (16 fraction bits, capped at 1.0), the
// base-10 LOD score (8 fraction bits, zero when negative) and an empty flag. Sustained
// rate is one item per cycle while out_stall is low. An item passes through the front
// register, the queue and the back-end stages. Most of the back end's depth is set by
// its log2 units (31 stages), which resolve one of 30 fraction bits per stage by
// repeated squaring. The dividers produce one quotient bit per stage in parallel with
// them. A result that waits under out_stall freezes the back end; the four-entry queue
// and the front register keep accepting input until they fill.
module ld_pair_statistics_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ldps_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ldps_pkg::out_item_t out_item
);

  logic            push, q_full, pop, q_empty;
  ldps_pkg::work_t push_item, pop_item;

  ldps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  ldps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  ldps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/ldps_front.sv]
// Front end: takes input items, forms the marginals and flags empty items.
module ldps_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ldps_pkg::in_item_t in_item,
  output logic              push,
  output ldps_pkg::work_t   push_item,
  input  logic              q_full
);

  logic            hold_valid_r, hold_valid_nxt;
  ldps_pkg::work_t hold_r, work;
  logic            accept;

  always_comb begin
    work.cnt   = in_item;
    work.n_a1  = {1'b0, in_item.count_a1b1} + {1'b0, in_item.count_a1b2};
    work.n_a2  = {1'b0, in_item.count_a2b1} + {1'b0, in_item.count_a2b2};
    work.n_b1  = {1'b0, in_item.count_a1b1} + {1'b0, in_item.count_a2b1};
    work.n_b2  = {1'b0, in_item.count_a1b2} + {1'b0, in_item.count_a2b2};
    work.n_all = {1'b0, work.n_a1} + {1'b0, work.n_a2};
    work.empty = (work.n_all == '0);
  end

  assign push      = hold_valid_r && !q_full;
  assign in_stall  = hold_valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push_item = hold_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= work;
    end
  end

endmodule

[rtl/ldps_queue.sv]
// Short queue of classified items between the front end and the back end.
module ldps_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ldps_pkg::work_t push_item,
  output logic            full,
  input  logic            pop,
  output ldps_pkg::work_t pop_item,
  output logic            empty
);

  localparam int DEPTH    = ldps_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  ldps_pkg::work_t      slot_r [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNT_BITS'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/ldps_delay.sv]
// Enabled shift register that carries a value down a fixed number of stages.
module ldps_delay #(
  parameter int WIDTH  = 1,
  parameter int STAGES = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
    end
  end

  for (genvar s = 1; s < STAGES; s++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[s] <= tap_r[s-1];
      end
    end
  end

  assign q = tap_r[STAGES-1];

endmodule

[rtl/ldps_log2.sv]
// Pipelined fixed-point log2: leading-one normalize, then one squaring per stage.
module ldps_log2 (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ldps_pkg::TOTAL_BITS-1:0]   x,
  output logic [ldps_pkg::LOG_BITS-1:0]     lg
);

  localparam int LF = ldps_pkg::LOG_FRAC;
  localparam int MW = LF + 1;

  logic [MW-1:0]                   man_r [LF+1];
  logic [ldps_pkg::LOG_BITS-1:0]   acc_r [LF+1];
  logic [ldps_pkg::EXP_BITS-1:0]   expo;
  logic [ldps_pkg::SHIFT_BITS-1:0] shamt;

  always_comb begin
    expo = '0;
    for (int i = 0; i < ldps_pkg::TOTAL_BITS; i++) begin
      if (x[i]) begin
        expo = ldps_pkg::EXP_BITS'(i);
      end
    end
    shamt = ldps_pkg::SHIFT_BITS'(LF) - ldps_pkg::SHIFT_BITS'(expo);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      man_r[0] <= MW'(x) << shamt;
      acc_r[0] <= {expo, {LF{1'b0}}};
    end
  end

  // Each stage squares the mantissa; a square of 2.0 or more yields a one bit.
  for (genvar k = 1; k <= LF; k++) begin : g_step
    logic [2*MW-1:0] sq;
    logic [MW:0]     top;
    assign sq  = man_r[k-1] * man_r[k-1];
    assign top = sq[LF +: MW+1];
    always_ff @(posedge clk) begin
      if (en) begin
        if (top[MW]) begin
          man_r[k] <= top[MW:1];
          acc_r[k] <= acc_r[k-1] | (ldps_pkg::LOG_BITS'(1) << (LF - k));
        end else begin
          man_r[k] <= top[MW-1:0];
          acc_r[k] <= acc_r[k-1];
        end
      end
    end
  end

  assign lg = acc_r[LF];

endmodule

[rtl/ldps_div.sv]
// Pipelined restoring divider for a ratio in [0,1], one quotient bit per stage.
module ldps_div #(
  parameter int NUM_BITS = 32,
  parameter int DEN_BITS = 32
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [NUM_BITS-1:0]            num,
  input  logic [DEN_BITS-1:0]            den,
  output logic [ldps_pkg::FRAC_WIDTH-1:0] quo
);

  localparam int QB = ldps_pkg::FRAC_WIDTH;
  localparam int NS = QB;
  localparam int RW = DEN_BITS + 1;
  localparam int CW = ((NUM_BITS > DEN_BITS) ? NUM_BITS : DEN_BITS) + 2;
  localparam logic [QB-1:0] ONE = QB'(1) << ldps_pkg::FRACTION_BITS;

  logic [RW-1:0]       rem_r  [NS+1];
  logic [DEN_BITS-1:0] dv_r   [NS+1];
  logic [QB-1:0]       q_r    [NS+1];
  logic                zero_r [NS+1];
  logic                big_r  [NS+1];

  // A numerator of twice the divisor or more already exceeds the cap.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= RW'(num);
      dv_r[0]   <= den;
      q_r[0]    <= '0;
      zero_r[0] <= (den == '0);
      big_r[0]  <= (CW'(num) >= (CW'(den) << 1));
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_step
    logic          ge;
    logic [RW-1:0] diff;
    assign ge   = (rem_r[s-1] >= RW'(dv_r[s-1]));
    assign diff = ge ? rem_r[s-1] - RW'(dv_r[s-1]) : rem_r[s-1];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= {diff[RW-2:0], 1'b0};
        dv_r[s]   <= dv_r[s-1];
        q_r[s]    <= {q_r[s-1][QB-2:0], ge};
        zero_r[s] <= zero_r[s-1];
        big_r[s]  <= big_r[s-1];
      end
    end
  end

  always_comb begin
    if (zero_r[NS]) begin
      quo = '0;
    end else if (big_r[NS] || (q_r[NS] > ONE)) begin
      quo = ONE;
    end else begin
      quo = q_r[NS];
    end
  end

endmodule

[rtl/ldps_back.sv]
// Back end: fixed-depth pipeline computing D', r squared and the LOD score.
module ldps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  ldps_pkg::work_t      q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ldps_pkg::out_item_t  out_item
);

  localparam int C    = ldps_pkg::COUNT_BITS;
  localparam int LB   = ldps_pkg::LOG_BITS;
  localparam int TB   = ldps_pkg::TOTAL_BITS;
  localparam int TW   = ldps_pkg::TERM_BITS;
  localparam int SB   = ldps_pkg::SUM_BITS;
  localparam int SPL  = ldps_pkg::LOD_SPLIT;
  localparam int PB   = ldps_pkg::LOD_PROD_BITS;
  localparam int FW   = ldps_pkg::FRAC_WIDTH;
  localparam int LW   = ldps_pkg::LOD_WIDTH;
  localparam int LOGL = ldps_pkg::LOG_FRAC + 1;
  localparam int LAST = LOGL + 6;
  localparam int DIVE = ldps_pkg::FRACTION_BITS + 5;
  localparam int CNTW = $bits(ldps_pkg::in_item_t);

  logic [LAST:0]   v_r;
  logic            adv;
  ldps_pkg::work_t w0_r;

  // The whole pipeline moves together; it holds only when a result waits.
  assign adv       = !v_r[LAST] || !out_stall;
  assign pop       = adv && !q_empty;
  assign out_valid = v_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAST-1:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w0_r <= q_item;
    end
  end

  // Correlation path.
  logic [ldps_pkg::PROD_BITS-1:0] pr1_r, qr1_r, d2_r, d3_r;
  logic [ldps_pkg::MIN_BITS-1:0]  mp1_r, mp2_r, mn1_r, mn2_r, dd1_r, dd2_r, m2_r, m3_r;
  logic [ldps_pkg::DEN_BITS-1:0]  den2_r, den3_r;
  logic [ldps_pkg::SQ_BITS-1:0]   dsq3_r;
  localparam int PRB = ldps_pkg::PROD_BITS;
  localparam int MB  = ldps_pkg::MIN_BITS;
  localparam int DB  = ldps_pkg::DEN_BITS;
  localparam int QB  = ldps_pkg::SQ_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      pr1_r <= PRB'(w0_r.cnt.count_a1b1) * PRB'(w0_r.cnt.count_a2b2);
      qr1_r <= PRB'(w0_r.cnt.count_a1b2) * PRB'(w0_r.cnt.count_a2b1);
      mp1_r <= MB'(w0_r.n_a1) * MB'(w0_r.n_b2);
      mp2_r <= MB'(w0_r.n_a2) * MB'(w0_r.n_b1);
      mn1_r <= MB'(w0_r.n_a1) * MB'(w0_r.n_b1);
      mn2_r <= MB'(w0_r.n_a2) * MB'(w0_r.n_b2);
      dd1_r <= MB'(w0_r.n_a1) * MB'(w0_r.n_a2);
      dd2_r <= MB'(w0_r.n_b1) * MB'(w0_r.n_b2);

      if (pr1_r > qr1_r) begin
        d2_r <= pr1_r - qr1_r;
        m2_r <= (mp1_r < mp2_r) ? mp1_r : mp2_r;
      end else begin
        d2_r <= qr1_r - pr1_r;
        m2_r <= (mn1_r < mn2_r) ? mn1_r : mn2_r;
      end
      den2_r <= DB'(dd1_r) * DB'(dd2_r);

      dsq3_r <= QB'(d2_r) * QB'(d2_r);
      d3_r   <= d2_r;
      m3_r   <= m2_r;
      den3_r <= den2_r;
    end
  end

  logic [FW-1:0] dp_q, r2_q, dp_out, r2_out;

  ldps_div #(.NUM_BITS(PRB), .DEN_BITS(MB)) u_div_dp (
    .clk (clk), .en (adv), .num (d3_r), .den (m3_r), .quo (dp_q)
  );

  ldps_div #(.NUM_BITS(QB), .DEN_BITS(DB)) u_div_r2 (
    .clk (clk), .en (adv), .num (dsq3_r), .den (den3_r), .quo (r2_q)
  );

  ldps_delay #(.WIDTH(FW), .STAGES(LAST - DIVE)) u_dly_dp (
    .clk (clk), .en (adv), .d (dp_q), .q (dp_out)
  );

  ldps_delay #(.WIDTH(FW), .STAGES(LAST - DIVE)) u_dly_r2 (
    .clk (clk), .en (adv), .d (r2_q), .q (r2_out)
  );

  logic empty_out;

  ldps_delay #(.WIDTH(1), .STAGES(LAST)) u_dly_empty (
    .clk (clk), .en (adv), .d (w0_r.empty), .q (empty_out)
  );

  // LOD path: nine logarithms, then the weighted sums.
  logic [TB-1:0] cell_in [4];
  logic [TB-1:0] marg_in [4];
  logic [LB-1:0] lg_cell [4];
  logic [LB-1:0] lg_marg [4];
  logic [LB-1:0] lg_all;

  assign cell_in[0] = TB'(w0_r.cnt.count_a1b1);
  assign cell_in[1] = TB'(w0_r.cnt.count_a1b2);
  assign cell_in[2] = TB'(w0_r.cnt.count_a2b1);
  assign cell_in[3] = TB'(w0_r.cnt.count_a2b2);
  assign marg_in[0] = TB'(w0_r.n_a1);
  assign marg_in[1] = TB'(w0_r.n_a2);
  assign marg_in[2] = TB'(w0_r.n_b1);
  assign marg_in[3] = TB'(w0_r.n_b2);

  for (genvar i = 0; i < 4; i++) begin : g_log
    ldps_log2 u_log_cell (.clk (clk), .en (adv), .x (cell_in[i]), .lg (lg_cell[i]));
    ldps_log2 u_log_marg (.clk (clk), .en (adv), .x (marg_in[i]), .lg (lg_marg[i]));
  end

  ldps_log2 u_log_all (.clk (clk), .en (adv), .x (w0_r.n_all), .lg (lg_all));

  logic [CNTW-1:0]    cnt_vec;
  ldps_pkg::in_item_t cnt_dly;
  logic [C-1:0]       cnt_l [4];

  ldps_delay #(.WIDTH(CNTW), .STAGES(LOGL)) u_dly_cnt (
    .clk (clk), .en (adv), .d (w0_r.cnt), .q (cnt_vec)
  );

  assign cnt_dly  = cnt_vec;
  assign cnt_l[0] = cnt_dly.count_a1b1;
  assign cnt_l[1] = cnt_dly.count_a1b2;
  assign cnt_l[2] = cnt_dly.count_a2b1;
  assign cnt_l[3] = cnt_dly.count_a2b2;

  // Marginals of each cell: A-row (a1 or a2) and B-column (b1 or b2).
  logic [LB:0]    s1_r [4];
  logic [LB:0]    t1_r [4];
  logic [C-1:0]   c1_r [4];
  logic [TW-1:0]  ps2_r [4];
  logic [TW-1:0]  ng2_r [4];
  logic [SB-1:0]  pos3_r, neg3_r, diff4_r;
  logic           gt4_r, gt5_r;
  logic [SPL+31:0]     pl5_r;
  logic [SB-SPL+31:0]  ph5_r;
  logic [LW-1:0]  lod_r;

  for (genvar i = 0; i < 4; i++) begin : g_term
    always_ff @(posedge clk) begin
      if (adv) begin
        c1_r[i] <= cnt_l[i];
        if (cnt_l[i] != '0) begin
          s1_r[i] <= (LB+1)'(lg_cell[i]) + (LB+1)'(lg_all);
          t1_r[i] <= (LB+1)'(lg_marg[i / 2]) + (LB+1)'(lg_marg[2 + (i % 2)]);
        end else begin
          s1_r[i] <= '0;
          t1_r[i] <= '0;
        end
        ps2_r[i] <= TW'(c1_r[i]) * TW'(s1_r[i]);
        ng2_r[i] <= TW'(c1_r[i]) * TW'(t1_r[i]);
      end
    end
  end

  logic [PB-1:0] lod_prod;

  assign lod_prod = (PB'(ph5_r) << SPL) + PB'(pl5_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      pos3_r <= SB'(ps2_r[0]) + SB'(ps2_r[1]) + SB'(ps2_r[2]) + SB'(ps2_r[3]);
      neg3_r <= SB'(ng2_r[0]) + SB'(ng2_r[1]) + SB'(ng2_r[2]) + SB'(ng2_r[3]);

      gt4_r   <= (pos3_r > neg3_r);
      diff4_r <= pos3_r - neg3_r;

      gt5_r <= gt4_r;
      pl5_r <= (SPL+32)'(diff4_r[SPL-1:0]) * (SPL+32)'(ldps_pkg::LOG10_2_Q32);
      ph5_r <= (SB-SPL+32)'(diff4_r[SB-1:SPL]) * (SB-SPL+32)'(ldps_pkg::LOG10_2_Q32);

      if (!gt5_r) begin
        lod_r <= '0;
      end else if (|lod_prod[PB-1:ldps_pkg::LOD_SHIFT+LW]) begin
        lod_r <= '1;
      end else begin
        lod_r <= lod_prod[ldps_pkg::LOD_SHIFT +: LW];
      end
    end
  end

  assign out_item.dprime_frac   = dp_out;
  assign out_item.rsquared_frac = r2_out;
  assign out_item.lod_score     = lod_r;
  assign out_item.empty_input   = empty_out;

endmodule

[rtl/ldps_checker.sv]
// Port-level checks for the linkage statistics block, bound to its top level.
module ldps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ldps_pkg::out_item_t out_item
);

  localparam logic [ldps_pkg::FRAC_WIDTH-1:0] ONE =
    ldps_pkg::FRAC_WIDTH'(1) << ldps_pkg::FRACTION_BITS;

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.empty_input |->
      out_item.dprime_frac == '0 && out_item.rsquared_frac == '0 &&
      out_item.lod_score == '0)
    else $error("empty item with nonzero statistics");

  a_frac_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.dprime_frac <= ONE && out_item.rsquared_frac <= ONE)
    else $error("ratio above 1.0");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("busy right after reset");

endmodule

bind ld_pair_statistics_core ldps_checker u_ldps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[bench/ld_pair_statistics_core_test.sv]
// Self-checking testbench for the pair linkage statistics core.
module ld_pair_statistics_core_test;
  import ldps_pkg::*;

  localparam int NUM_RANDOM = 1030;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    in_item_t  cnt;
    logic      has_expect;
    out_item_t expect_item;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  out_item_t pending_stats[$];
  int        mismatches;
  bit        hold_receiver;

  ld_pair_statistics_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // log2 with LOG_FRAC fraction bits, refined by repeated squaring.
  function automatic logic [63:0] log2_q30(input logic [63:0] x);
    int unsigned e;
    logic [63:0] mant;
    logic [127:0] sq;
    logic [63:0] res;
    e = 0;
    if (x == 0) return 64'd0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    mant = (e <= LOG_FRAC) ? (x << (LOG_FRAC - e)) : (x >> (e - LOG_FRAC));
    res = 64'(e) << LOG_FRAC;
    for (int k = LOG_FRAC - 1; k >= 0; k--) begin
      sq = 128'(mant) * 128'(mant);
      mant = 64'(sq >> LOG_FRAC);
      if (mant >= (64'd2 << LOG_FRAC)) begin
        mant = mant >> 1;
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic out_item_t linkage_stats(input in_item_t c);
    logic [63:0] cab1, cab2, cab3, cab4, tot, na1, na2, nb1, nb2;
    logic [63:0] pr, qr, d, m, m1, m2, ln, pos, neg;
    logic [127:0] q, w;
    logic [63:0] tally[4], mx[4], my[4];
    out_item_t r;
    r = '0;
    cab1 = c.count_a1b1; cab2 = c.count_a1b2; cab3 = c.count_a2b1; cab4 = c.count_a2b2;
    tot = cab1 + cab2 + cab3 + cab4;
    if (tot == 0) begin
      r.empty_input = 1'b1;
      return r;
    end
    na1 = cab1 + cab2; na2 = cab3 + cab4; nb1 = cab1 + cab3; nb2 = cab2 + cab4;
    pr = cab1 * cab4;
    qr = cab2 * cab3;
    d = (pr > qr) ? pr - qr : qr - pr;
    if (pr > qr) begin
      m1 = na1 * nb2; m2 = na2 * nb1;
    end else begin
      m1 = na1 * nb1; m2 = na2 * nb2;
    end
    m = (m1 < m2) ? m1 : m2;
    if (m != 0) begin
      q = (128'(d) << FRACTION_BITS) / 128'(m);
      r.dprime_frac = (q > (128'd1 << FRACTION_BITS)) ?
                      (FRAC_WIDTH'(1) << FRACTION_BITS) : q[FRAC_WIDTH-1:0];
    end
    if (na1 != 0 && na2 != 0 && nb1 != 0 && nb2 != 0) begin
      q = ((128'(d) * 128'(d)) << FRACTION_BITS) / (128'(na1 * na2) * 128'(nb1 * nb2));
      r.rsquared_frac = (q > (128'd1 << FRACTION_BITS)) ?
                        (FRAC_WIDTH'(1) << FRACTION_BITS) : q[FRAC_WIDTH-1:0];
    end
    tally = '{cab1, cab2, cab3, cab4};
    mx = '{na1, na1, na2, na2};
    my = '{nb1, nb2, nb1, nb2};
    ln = log2_q30(tot);
    pos = 0;
    neg = 0;
    for (int i = 0; i < 4; i++) begin
      if (tally[i] != 0) begin
        pos += tally[i] * (log2_q30(tally[i]) + ln);
        neg += tally[i] * (log2_q30(mx[i]) + log2_q30(my[i]));
      end
    end
    if (pos > neg) begin
      w = 128'(pos - neg) * 128'(LOG10_2_Q32);
      w = w >> LOD_SHIFT;
      r.lod_score = (w >= (128'd1 << LOD_WIDTH)) ? '1 : w[LOD_WIDTH-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // in_valid stays high after an accepted item; this task drops it only when a gap is drawn.
  task automatic send_counts(input in_item_t c, input out_item_t want, input bit typed);
    out_item_t model;
    int gap;
    model = linkage_stats(c);
    if (typed && model !== want) report_mismatch("directed row predictor", 0, 1);
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_stats.push_back(model);
  endtask

  function automatic in_item_t random_counts();
    in_item_t c;
    int shape;
    shape = $urandom_range(0, 5);
    c.count_a1b1 = COUNT_BITS'($urandom); c.count_a1b2 = COUNT_BITS'($urandom);
    c.count_a2b1 = COUNT_BITS'($urandom); c.count_a2b2 = COUNT_BITS'($urandom);
    if (shape == 1) begin
      c.count_a1b1 = COUNT_BITS'($urandom_range(0, 20));
      c.count_a1b2 = COUNT_BITS'($urandom_range(0, 20));
      c.count_a2b1 = COUNT_BITS'($urandom_range(0, 20));
      c.count_a2b2 = COUNT_BITS'($urandom_range(0, 20));
    end else if (shape == 2) begin
      if ($urandom_range(0, 1)) c.count_a1b2 = 0; else c.count_a2b1 = 0;
      if ($urandom_range(0, 1)) c.count_a2b2 = 0;
    end else if (shape == 3) begin
      c.count_a1b2 = COUNT_BITS'($urandom_range(0, 3));
      c.count_a2b1 = COUNT_BITS'($urandom_range(0, 3));
    end else if (shape == 4) begin
      c.count_a1b1 = 0; c.count_a2b2 = 0;
    end
    return c;
  endfunction

  // Receiver: random stall per item, plus one long hold-off.
  initial begin
    int wait_cycles;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_receiver) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        hold_receiver = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("result with nothing expected", 1, 0);
      end else begin
        out_item_t want;
        want = pending_stats.pop_front();
        if (out_item.dprime_frac !== want.dprime_frac)
          report_mismatch("dprime_frac", 32'(out_item.dprime_frac),
                          32'(want.dprime_frac));
        if (out_item.rsquared_frac !== want.rsquared_frac)
          report_mismatch("rsquared_frac", 32'(out_item.rsquared_frac),
                          32'(want.rsquared_frac));
        if (out_item.lod_score !== want.lod_score)
          report_mismatch("lod_score", 32'(out_item.lod_score), 32'(want.lod_score));
        if (out_item.empty_input !== want.empty_input)
          report_mismatch("empty_input", 32'(out_item.empty_input),
                          32'(want.empty_input));
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    mismatches = 0;
    hold_receiver = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty item, typed in.
    row.cnt = '0; row.has_expect = 1; row.expect_item = '{0, 0, 0, 1'b1};
    rows.push_back(row);
    // Only the two coupling cells: complete positive linkage, D' and r^2 both one.
    row.cnt = '{16'd10, 16'd0, 16'd0, 16'd10}; row.has_expect = 1;
    row.expect_item = linkage_stats(row.cnt);
    row.expect_item.dprime_frac = 17'h10000; row.expect_item.rsquared_frac = 17'h10000;
    rows.push_back(row);
    // Only repulsion cells: complete negative linkage.
    row.cnt = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0}; row.has_expect = 1;
    row.expect_item = linkage_stats(row.cnt);
    row.expect_item.dprime_frac = 17'h10000; row.expect_item.rsquared_frac = 17'h10000;
    rows.push_back(row);
    // Zero marginal: r^2, D' and LOD all zero.
    row.cnt = '{16'd5, 16'd7, 16'd0, 16'd0}; row.has_expect = 1;
    row.expect_item = '{0, 0, 0, 1'b0};
    rows.push_back(row);
    // Single nonzero cell.
    row.cnt = '{16'd0, 16'd0, 16'd0, 16'hFFFF}; row.has_expect = 1;
    row.expect_item = '{0, 0, 0, 1'b0};
    rows.push_back(row);
    // Independence: all cells equal gives zero everywhere.
    row.cnt = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}; row.has_expect = 1;
    row.expect_item = '{0, 0, 0, 1'b0};
    rows.push_back(row);
    row.has_expect = 0;
    row.cnt = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF}; rows.push_back(row);
    row.cnt = '{16'hFFFF, 16'd1, 16'd1, 16'hFFFF}; rows.push_back(row);
    row.cnt = '{16'd1, 16'hFFFF, 16'hFFFF, 16'd1}; rows.push_back(row);
    row.cnt = '{16'h8000, 16'h4000, 16'h2000, 16'h1000}; rows.push_back(row);
    row.cnt = '{16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00}; rows.push_back(row);
    row.cnt = '{16'd1, 16'd0, 16'd0, 16'd0}; rows.push_back(row);
    row.cnt = '{16'd3, 16'd1, 16'd1, 16'd0}; rows.push_back(row);
    row.cnt = '{16'd0, 16'd2, 16'd3, 16'd9}; rows.push_back(row);
    row.cnt = '{16'hFFFF, 16'd0, 16'd1, 16'd0}; rows.push_back(row);
    row.cnt = '{16'd100, 16'd1, 16'd2, 16'd1}; rows.push_back(row);

    foreach (rows[i]) send_counts(rows[i].cnt, rows[i].expect_item, rows[i].has_expect);

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == 200) hold_receiver = 1'b1;
      if (k == 600) begin
        // Let the pipeline drain completely before going on.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0) @(posedge clk);
      end
      if (k >= 200 && k < 240) begin
        in_valid <= 1'b1;
        in_item  <= random_counts();
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_stats.push_back(linkage_stats(in_item));
      end else begin
        send_counts(random_counts(), '0, 1'b0);
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_stats.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_stats.size() != 0)
      report_mismatch("results never arrived", 0, pending_stats.size());
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
